// ===== hdl/kvt_pkg.sv =====
// Package for the keyed table: sizes, operation and status codes, shared types.
// No dependencies; every other file of the table imports it.
package kvt_pkg;

  localparam int MaxEntries  = 64;
  localparam int PayloadBits = 64;

  localparam int OpW     = 3;
  localparam int KeyW    = 32;
  localparam int PayW    = 64;
  localparam int StatW   = 3;
  localparam int CapW    = 7;
  localparam int OutCntW = 7;
  localparam int CntW    = $clog2(MaxEntries + 1);
  localparam int ExtW    = (CntW > CapW) ? CntW : CapW;

  localparam logic [CapW-1:0] CapReset = CapW'(64);

  typedef enum logic [OpW-1:0] {
    OP_ADD    = 3'd0,
    OP_DELETE = 3'd1,
    OP_UPDATE = 3'd2,
    OP_GET    = 3'd3,
    OP_CLEAR  = 3'd4
  } kvt_op_e;

  typedef enum logic [StatW-1:0] {
    ST_OK      = 3'd0,
    ST_FULL    = 3'd1,
    ST_DUP     = 3'd2,
    ST_MISSING = 3'd3,
    ST_NEWKEY  = 3'd4
  } kvt_status_e;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } kvt_state_e;

  typedef logic [PayloadBits-1:0] kvt_pay_t;

  // per-cell command for the update cycle
  typedef struct packed {
    logic load;   // take write key and payload
    logic shift;  // take contents of the next cell up
  } kvt_cell_ctl_t;

  // bit i = OR of bits 0..i, log-depth
  function automatic logic [MaxEntries-1:0] prefix_or(input logic [MaxEntries-1:0] v);
    logic [MaxEntries-1:0] r;
    r = v;
    for (int s = 1; s < MaxEntries; s = s * 2) begin
      r = r | (r << s);
    end
    return r;
  endfunction

endpackage

// ===== hdl/kvt_intf.sv =====
// Channel interfaces of the keyed table: request, response and capacity write.
// Depends on kvt_pkg for field widths.
interface kvt_req_if;
  import kvt_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [OpW-1:0]         operation;
  logic signed [KeyW-1:0] key;
  logic signed [KeyW-1:0] new_key;
  logic [PayW-1:0]        payload;
  modport source (output valid, operation, key, new_key, payload, input ready);
  modport sink   (input valid, operation, key, new_key, payload, output ready);
endinterface

interface kvt_rsp_if;
  import kvt_pkg::*;
  logic               valid;
  logic               ready;
  logic [StatW-1:0]   status;
  logic [PayW-1:0]    found_payload;
  logic [OutCntW-1:0] entry_count;
  modport source (output valid, status, found_payload, entry_count, input ready);
  modport sink   (input valid, status, found_payload, entry_count, output ready);
endinterface

interface kvt_cfg_if;
  import kvt_pkg::*;
  logic            valid;
  logic            ready;
  logic [CapW-1:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ===== hdl/kvt_cell.sv =====
// One slot of the keyed table: key, payload and the registered compare results.
// Depends on kvt_pkg; takes the next cell's contents when the table compacts.
module kvt_cell (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cmp_en_i,
  input  logic                   occ_i,
  input  logic [kvt_pkg::KeyW-1:0] key_i,
  input  logic [kvt_pkg::KeyW-1:0] new_key_i,
  input  kvt_pkg::kvt_cell_ctl_t ctl_i,
  input  logic [kvt_pkg::KeyW-1:0] wr_key_i,
  input  kvt_pkg::kvt_pay_t      wr_pay_i,
  input  logic [kvt_pkg::KeyW-1:0] nbr_key_i,
  input  kvt_pkg::kvt_pay_t      nbr_pay_i,
  output logic [kvt_pkg::KeyW-1:0] key_o,
  output kvt_pkg::kvt_pay_t      pay_o,
  output logic                   match_k_o,
  output logic                   match_nk_o
);
  import kvt_pkg::*;

  logic [KeyW-1:0] key_q, key_d;
  kvt_pay_t        pay_q, pay_d;
  logic            mk_q, mk_d, mn_q, mn_d;

  always_comb begin
    key_d = key_q;
    pay_d = pay_q;
    if (ctl_i.load) begin
      key_d = wr_key_i;
      pay_d = wr_pay_i;
    end else if (ctl_i.shift) begin
      key_d = nbr_key_i;
      pay_d = nbr_pay_i;
    end
  end

  // compares run in the accept cycle, results held through the update cycle
  always_comb begin
    mk_d = mk_q;
    mn_d = mn_q;
    if (cmp_en_i) begin
      mk_d = occ_i && (key_q == key_i);
      mn_d = occ_i && (key_q == new_key_i);
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    pay_q <= pay_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mk_q <= 1'b0;
      mn_q <= 1'b0;
    end else begin
      mk_q <= mk_d;
      mn_q <= mn_d;
    end
  end

  assign key_o      = key_q;
  assign pay_o      = pay_q;
  assign match_k_o  = mk_q;
  assign match_nk_o = mn_q;

endmodule

// ===== hdl/keyed_table_insert_delete_lookup.sv =====
// Top level of the keyed table: control sequencer, output register and the row of cells.
// Depends on kvt_pkg, kvt_intf (channel interfaces) and kvt_cell.
//
//  channel | role   | moves
//  --------+--------+-----------------------------------------------
//  in_i    | sink   | operation, key, new_key, payload
//  out_o   | source | status, found_payload, entry_count
//  cfg_i   | sink   | capacity (always ready)
//
// A transaction is accepted, then applied: on the accept edge every cell compares its key
// against key and new_key; in the update cycle the operation is applied to the row
// and the result is loaded into the output register. The update cycle waits while
// a previous result is still held in that register. Reset clears the entry count
// and sets capacity to 64; slots at or above the count are never read, so no
// clearing pass is needed.
module keyed_table_insert_delete_lookup (
  input  logic clk_i,
  input  logic rst_ni,
  kvt_req_if.sink   in_i,
  kvt_rsp_if.source out_o,
  kvt_cfg_if.sink   cfg_i
);
  import kvt_pkg::*;

  kvt_state_e state_q, state_d;

  logic [OpW-1:0]  op_q;
  logic [KeyW-1:0] key_q, nkey_q;
  kvt_pay_t        pay_q;
  logic [CntW-1:0] count_q, count_d;
  logic [CapW-1:0] cap_q;

  logic             out_valid_q, out_valid_d;
  logic [StatW-1:0] status_q, status_d;
  logic [PayW-1:0]  found_q, found_d;

  logic in_fire, exec_fire, full, any_k, any_nk;
  logic [MaxEntries-1:0] occ, match_k, match_nk, thermo;
  kvt_cell_ctl_t         ctl [MaxEntries];
  logic [KeyW-1:0]       cell_key [MaxEntries];
  kvt_pay_t              cell_pay [MaxEntries];
  logic [KeyW-1:0]       wr_key;
  kvt_pay_t              found_pay;

  assign in_i.ready  = (state_q == S_IDLE);
  assign in_fire     = in_i.valid && in_i.ready;
  assign exec_fire   = (state_q == S_EXEC) && (!out_valid_q || out_o.ready);
  assign cfg_i.ready = 1'b1;

  assign any_k  = |match_k;
  assign any_nk = |match_nk;
  assign thermo = prefix_or(match_k);
  assign full   = (count_q >= CntW'(MaxEntries)) || (ExtW'(count_q) >= ExtW'(cap_q));
  assign wr_key = (op_q == OP_UPDATE) ? nkey_q : key_q;

  always_comb begin
    found_pay = '0;
    for (int i = 0; i < MaxEntries; i++) begin
      found_pay = found_pay | (cell_pay[i] & {PayloadBits{match_k[i]}});
    end
  end

  for (genvar i = 0; i < MaxEntries; i++) begin : g_cell
    logic [KeyW-1:0] nbr_key;
    kvt_pay_t        nbr_pay;

    assign occ[i] = (count_q > CntW'(i));

    always_comb begin
      ctl[i].load  = exec_fire &&
                     (((op_q == OP_ADD) && !full && !any_k && (count_q == CntW'(i))) ||
                      ((op_q == OP_UPDATE) && !any_nk && match_k[i]));
      ctl[i].shift = exec_fire && (op_q == OP_DELETE) && thermo[i];
    end

    if (i == MaxEntries - 1) begin : g_last
      assign nbr_key = cell_key[i];
      assign nbr_pay = cell_pay[i];
    end else begin : g_mid
      assign nbr_key = cell_key[i+1];
      assign nbr_pay = cell_pay[i+1];
    end

    kvt_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cmp_en_i   (in_fire),
      .occ_i      (occ[i]),
      .key_i      (in_i.key),
      .new_key_i  (in_i.new_key),
      .ctl_i      (ctl[i]),
      .wr_key_i   (wr_key),
      .wr_pay_i   (pay_q),
      .nbr_key_i  (nbr_key),
      .nbr_pay_i  (nbr_pay),
      .key_o      (cell_key[i]),
      .pay_o      (cell_pay[i]),
      .match_k_o  (match_k[i]),
      .match_nk_o (match_nk[i])
    );
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    status_d    = status_q;
    found_d     = found_q;
    out_valid_d = out_valid_q && !out_o.ready;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (exec_fire) begin
          state_d     = S_IDLE;
          out_valid_d = 1'b1;
          status_d    = ST_OK;
          found_d     = '0;
          case (op_q)
            OP_ADD: begin
              if (full) begin
                status_d = ST_FULL;
              end else if (any_k) begin
                status_d = ST_DUP;
              end else begin
                count_d = count_q + CntW'(1);
              end
            end
            OP_DELETE: begin
              if (!any_k) begin
                status_d = ST_MISSING;
              end else begin
                count_d = count_q - CntW'(1);
              end
            end
            OP_UPDATE: begin
              if (any_nk) begin
                status_d = ST_NEWKEY;
              end else if (!any_k) begin
                status_d = ST_MISSING;
              end
            end
            OP_GET: begin
              if (!any_k) begin
                status_d = ST_MISSING;
              end else begin
                found_d = PayW'(found_pay);
              end
            end
            OP_CLEAR: begin
              count_d = '0;
            end
            default: ;
          endcase
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      cap_q       <= CapReset;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      if (cfg_i.valid && cfg_i.ready) begin
        cap_q <= cfg_i.data;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    found_q  <= found_d;
    if (in_fire) begin
      op_q   <= in_i.operation;
      key_q  <= in_i.key;
      nkey_q <= in_i.new_key;
      pay_q  <= in_i.payload[PayloadBits-1:0];
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.status        = status_q;
  assign out_o.found_payload = found_q;
  assign out_o.entry_count   = OutCntW'(count_q);

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MaxEntries))
    else $error("entry count above table size");

  a_keys_unique: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC) |-> ($onehot0(match_k) && $onehot0(match_nk)))
    else $error("more than one slot matched a key");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_EXEC) && out_valid_q && !out_o.ready) |=> (state_q == S_EXEC))
    else $error("update applied while result still pending");

  a_count_only_on_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !exec_fire |=> $stable(count_q))
    else $error("entry count changed outside update cycle");
`endif

endmodule

// ===== tb/keyed_table_insert_delete_lookup_tb.sv =====
// Self-checking testbench for keyed_table_insert_delete_lookup: directed table, then random phases.
// Depends on kvt_pkg, the kvt_intf channel interfaces and the top-level RTL.
`timescale 1ns / 100ps
module keyed_table_insert_delete_lookup_tb;
  import kvt_pkg::*;

  typedef struct packed {
    logic [OpW-1:0]  op;
    logic [KeyW-1:0] key;
    logic [KeyW-1:0] new_key;
    logic [PayW-1:0] payload;
  } kvt_req_t;

  typedef struct packed {
    logic [StatW-1:0]   status;
    logic [PayW-1:0]    found;
    logic [OutCntW-1:0] count;
  } kvt_rsp_t;

  typedef struct {
    kvt_req_t req;
    bit       typed;
    kvt_rsp_t want;
  } dir_row_t;

  localparam logic [KeyW-1:0] KeyMin     = 32'h8000_0000;
  localparam logic [KeyW-1:0] KeyMax     = 32'h7fff_ffff;
  localparam logic [KeyW-1:0] KeyAllOnes = 32'hffff_ffff;
  localparam logic [PayW-1:0] PayOnes    = {PayW{1'b1}};
  localparam logic [OpW-1:0]  OpRsvdLo   = 3'd5;
  localparam logic [OpW-1:0]  OpRsvdMid  = 3'd6;
  localparam logic [OpW-1:0]  OpRsvdHi   = 3'd7;
  localparam logic [CapW-1:0] CapTop     = 7'd127;
  localparam int PoolSize      = 96;
  localparam int MaxGap        = 16;
  localparam int HoldOffCycles = 150;
  localparam int DrainCycles   = 8;

  logic clk;
  logic rst_n;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  kvt_req_if req_if ();
  kvt_rsp_if rsp_if ();
  kvt_cfg_if cfg_if ();

  keyed_table_insert_delete_lookup uut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (req_if),
    .out_o (rsp_if),
    .cfg_i (cfg_if)
  );

  // shadow copy of the table
  logic [KeyW-1:0] tbl_key[MaxEntries];
  logic [PayW-1:0] tbl_pay[MaxEntries];
  int unsigned     tbl_count;
  logic [CapW-1:0] tbl_cap;

  kvt_rsp_t        pending_rsp[$];
  dir_row_t        dir_rows[$];
  logic [KeyW-1:0] key_pool[PoolSize];

  bit send_steady;
  bit recv_steady;
  bit hold_off_req;
  int n_err;
  int n_sent;
  int n_cfg;
  int n_full;
  int unsigned peak;

  function automatic int slot_of(logic [KeyW-1:0] k);
    for (int i = 0; i < tbl_count; i++) begin
      if (tbl_key[i] == k) return i;
    end
    return -1;
  endfunction

  function automatic kvt_rsp_t apply_to_table(kvt_req_t r);
    kvt_rsp_t    res;
    int          s;
    int unsigned lim;
    res = '0;
    res.status = ST_OK;
    lim = (tbl_cap < MaxEntries) ? tbl_cap : MaxEntries;
    case (r.op)
      OP_ADD: begin
        if (tbl_count >= lim) begin
          res.status = ST_FULL;
        end else if (slot_of(r.key) >= 0) begin
          res.status = ST_DUP;
        end else begin
          tbl_key[tbl_count] = r.key;
          tbl_pay[tbl_count] = r.payload;
          tbl_count++;
        end
      end
      OP_DELETE: begin
        s = slot_of(r.key);
        if (s < 0) begin
          res.status = ST_MISSING;
        end else begin
          // keep insertion order: move later entries down one slot
          for (int i = s; i + 1 < tbl_count; i++) begin
            tbl_key[i] = tbl_key[i+1];
            tbl_pay[i] = tbl_pay[i+1];
          end
          tbl_count--;
        end
      end
      OP_UPDATE: begin
        if (slot_of(r.new_key) >= 0) begin
          res.status = ST_NEWKEY;
        end else begin
          s = slot_of(r.key);
          if (s < 0) begin
            res.status = ST_MISSING;
          end else begin
            tbl_key[s] = r.new_key;
            tbl_pay[s] = r.payload;
          end
        end
      end
      OP_GET: begin
        s = slot_of(r.key);
        if (s < 0) res.status = ST_MISSING;
        else res.found = tbl_pay[s];
      end
      OP_CLEAR: tbl_count = 0;
      default: ;
    endcase
    res.count = OutCntW'(tbl_count);
    return res;
  endfunction

  function automatic void add_row(logic [OpW-1:0] op, logic [KeyW-1:0] k, logic [KeyW-1:0] nk,
                                  logic [PayW-1:0] p, bit typed, logic [StatW-1:0] st,
                                  logic [PayW-1:0] fp, logic [OutCntW-1:0] cnt);
    dir_row_t row;
    row.req   = '{op: op, key: k, new_key: nk, payload: p};
    row.typed = typed;
    row.want  = '{status: st, found: fp, count: cnt};
    dir_rows.push_back(row);
  endfunction

  function automatic int draw_gap(bit steady);
    return steady ? 0 : $urandom_range(0, MaxGap);
  endfunction

  // with from_table set, mostly keys already held, so hits are common; else pool keys; some fully random
  function automatic logic [KeyW-1:0] pick_key(bit from_table);
    int r;
    r = $urandom_range(0, 99);
    if (from_table && tbl_count > 0 && r < 55) return tbl_key[$urandom_range(0, tbl_count - 1)];
    if (r >= 95) return $urandom;
    return key_pool[$urandom_range(0, PoolSize - 1)];
  endfunction

  function automatic logic [PayW-1:0] pick_payload();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return '0;
    if (r < 10) return PayOnes;
    return {$urandom, $urandom};
  endfunction

  function automatic kvt_req_t make_random_item(int add_pct);
    kvt_req_t it;
    int       q;
    it.payload = pick_payload();
    it.new_key = pick_key($urandom_range(0, 2) == 0);
    if ($urandom_range(0, 99) < add_pct) begin
      it.op  = OP_ADD;
      it.key = pick_key($urandom_range(0, 4) == 0);
    end else begin
      q = $urandom_range(0, 99);
      if (q < 25) it.op = OP_DELETE;
      else if (q < 50) it.op = OP_UPDATE;
      else if (q < 92) it.op = OP_GET;
      else if (q < 95) it.op = OP_CLEAR;
      else it.op = OpW'($urandom_range(OpRsvdLo, OpRsvdHi));
      it.key = pick_key(1'b1);
    end
    return it;
  endfunction

  // called at a falling edge; returns at the falling edge after the transaction
  task automatic send_item(kvt_req_t r, bit typed, kvt_rsp_t want);
    int       gap;
    kvt_rsp_t got;
    gap = draw_gap(send_steady);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_if.valid     <= 1'b1;
    req_if.operation <= r.op;
    req_if.key       <= r.key;
    req_if.new_key   <= r.new_key;
    req_if.payload   <= r.payload;
    do @(posedge clk); while (!(req_if.valid && req_if.ready));
    got = apply_to_table(r);
    pending_rsp.push_back(typed ? want : got);
    n_sent++;
    if (tbl_count > peak) peak = tbl_count;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    while (pending_rsp.size() != 0) @(posedge clk);
  endtask

  task automatic write_capacity(logic [CapW-1:0] v);
    wait_drained();
    repeat (DrainCycles) @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= v;
    do @(posedge clk); while (!(cfg_if.valid && cfg_if.ready));
    tbl_cap = v;
    n_cfg++;
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic run_phase(logic [CapW-1:0] cap, int add_pct, int items, bit s_steady,
                           bit r_steady, bit pressure, int pause_at);
    write_capacity(cap);
    send_steady = s_steady;
    recv_steady = r_steady;
    if (pressure) hold_off_req = 1'b1;
    for (int i = 0; i < items; i++) begin
      if (i == pause_at) begin
        req_if.valid <= 1'b0;
        wait_drained();
        @(negedge clk);
      end
      send_item(make_random_item(add_pct), 1'b0, '0);
    end
    req_if.valid <= 1'b0;
  endtask

  // response side: random back-pressure, plus one long hold-off on request
  initial begin : rsp_sink
    int gap;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (hold_off_req) begin
        gap = HoldOffCycles;
        hold_off_req = 1'b0;
      end else begin
        gap = draw_gap(recv_steady);
      end
      if (gap > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk); while (!(rsp_if.valid && rsp_if.ready));
      @(negedge clk);
    end
  end

  always @(posedge clk) begin : rsp_check
    kvt_rsp_t want;
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      if (pending_rsp.size() == 0) begin
        $error("unexpected response: status %0d, entry_count %0d",
               rsp_if.status, rsp_if.entry_count);
        n_err++;
      end else begin
        want = pending_rsp.pop_front();
        if (rsp_if.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, rsp_if.status);
          n_err++;
        end
        if (rsp_if.found_payload !== want.found) begin
          $error("found_payload: expected %h, actual %h", want.found, rsp_if.found_payload);
          n_err++;
        end
        if (rsp_if.entry_count !== want.count) begin
          $error("entry_count: expected %0d, actual %0d", want.count, rsp_if.entry_count);
          n_err++;
        end
      end
      if (rsp_if.status == ST_FULL) n_full++;
    end
  end

  initial begin : run_limit
    #3_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin : stimulus
    req_if.valid     = 1'b0;
    req_if.operation = '0;
    req_if.key       = '0;
    req_if.new_key   = '0;
    req_if.payload   = '0;
    rsp_if.ready     = 1'b0;
    cfg_if.valid     = 1'b0;
    cfg_if.data      = '0;
    rst_n            = 1'b0;
    send_steady      = 1'b0;
    recv_steady      = 1'b0;
    hold_off_req     = 1'b0;
    n_err            = 0;
    n_sent           = 0;
    n_cfg            = 0;
    n_full           = 0;
    peak             = 0;
    tbl_count        = 0;
    tbl_cap          = CapReset;

    key_pool[0] = KeyMin;
    key_pool[1] = KeyMax;
    key_pool[2] = '0;
    key_pool[3] = KeyAllOnes;
    for (int i = 4; i < PoolSize; i++) key_pool[i] = $urandom;

    // capacity 3 during this table
    add_row(OP_GET,    32'd5,  32'd0,  '0, 1'b1, ST_MISSING, '0, 7'd0);
    add_row(OP_DELETE, 32'd5,  32'd0,  '0, 1'b1, ST_MISSING, '0, 7'd0);
    add_row(OP_UPDATE, 32'd5,  32'd6,  PayOnes, 1'b1, ST_MISSING, '0, 7'd0);
    add_row(OP_ADD,    KeyMin, KeyMax, '0, 1'b1, ST_OK, '0, 7'd1);
    add_row(OP_ADD,    KeyMax, KeyMin, PayOnes, 1'b1, ST_OK, '0, 7'd2);
    add_row(OP_ADD,    KeyMin, 32'd0,  64'd5, 1'b1, ST_DUP, '0, 7'd2);
    add_row(OP_GET,    KeyMax, 32'd0,  '0, 1'b1, ST_OK, PayOnes, 7'd2);
    add_row(OP_GET,    KeyMin, 32'd0,  PayOnes, 1'b1, ST_OK, '0, 7'd2);
    add_row(OP_ADD,    32'd0,  32'd0,  64'h0123_4567_89ab_cdef, 1'b1, ST_OK, '0, 7'd3);
    add_row(OP_ADD,    32'd1,  32'd0,  PayOnes, 1'b1, ST_FULL, '0, 7'd3);
    // new key equal to the entry's own key still counts as existing
    add_row(OP_UPDATE, KeyMax, KeyMax, '0, 1'b1, ST_NEWKEY, '0, 7'd3);
    add_row(OP_UPDATE, KeyMin, 32'd0,  '0, 1'b1, ST_NEWKEY, '0, 7'd3);
    add_row(OP_UPDATE, 32'd42, 32'd43, '0, 1'b1, ST_MISSING, '0, 7'd3);
    add_row(OP_UPDATE, 32'd0,  KeyAllOnes, 64'ha5a5_5a5a_f00f_0ff0, 1'b0, ST_OK, '0, '0);
    add_row(OP_GET,    KeyAllOnes, 32'd0, '0, 1'b0, ST_OK, '0, '0);
    add_row(OP_GET,    32'd0,  32'd0,  '0, 1'b0, ST_OK, '0, '0);
    add_row(OP_DELETE, KeyMin, 32'd0,  '0, 1'b0, ST_OK, '0, '0);
    add_row(OP_GET,    KeyMax, 32'd0,  '0, 1'b0, ST_OK, '0, '0);
    add_row(OpRsvdLo,  32'd1,  32'd2,  PayOnes, 1'b1, ST_OK, '0, 7'd2);
    add_row(OpRsvdMid, KeyMax, KeyMin, PayOnes, 1'b1, ST_OK, '0, 7'd2);
    add_row(OpRsvdHi,  KeyAllOnes, KeyAllOnes, PayOnes, 1'b1, ST_OK, '0, 7'd2);
    add_row(OP_CLEAR,  32'd0,  32'd0,  '0, 1'b1, ST_OK, '0, 7'd0);
    add_row(OP_GET,    KeyAllOnes, 32'd0, '0, 1'b1, ST_MISSING, '0, 7'd0);
    add_row(OP_ADD,    32'd7,  32'd0,  PayOnes, 1'b0, ST_OK, '0, '0);
    add_row(OP_ADD,    32'd8,  32'd0,  64'h8000_0000_0000_0001, 1'b0, ST_OK, '0, '0);

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    write_capacity(7'd3);
    foreach (dir_rows[i]) send_item(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);
    req_if.valid <= 1'b0;

    // capacity 0 lands below the current count
    run_phase(7'd0,  40, 120, 1'b0, 1'b0, 1'b0, -1);
    run_phase(CapTop, 75, 150, 1'b0, 1'b0, 1'b0, -1);
    run_phase(7'd64, 45, 150, 1'b1, 1'b0, 1'b1, -1);
    run_phase(7'd2,  50, 120, 1'b0, 1'b0, 1'b0, -1);
    run_phase(CapW'($urandom_range(0, 127)), 50, 150, 1'b0, 1'b1, 1'b0, -1);
    run_phase(7'd40, 60, 150, 1'b1, 1'b1, 1'b0, -1);
    run_phase(7'd64, 45, 180, 1'b0, 1'b0, 1'b0, 90);

    wait_drained();
    repeat (DrainCycles) @(posedge clk);
    $display("Covered %0d transactions under %0d capacity settings (0 to 127).", n_sent, n_cfg);
    $display("Peak occupancy %0d, %0d table-full rejects, %0d mismatches.", peak, n_full, n_err);
    if (n_err == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
